### rtl/dtq_pkg.sv
// package for the deadline timer queue: sizes, word types, status codes
// no dependencies
`default_nettype none
package dtq_pkg;
  localparam int unsigned Capacity   = 16;
  localparam int unsigned IdxW       = $clog2(Capacity);
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam int unsigned MaxResults = 16;
  localparam int unsigned EmitW      = $clog2(MaxResults + 1);

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StExpired  = 2'd2;

  localparam logic OpInsert = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [23:0] delay;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] timer_id;
    logic        last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture input word, advance time on tick
    logic ptr_clr;     // pointer to zero
    logic ptr_to_cnt;  // pointer to count
    logic rd_prev;     // read entry at ptr-1 (default read is at ptr)
    logic rd_next;     // read entry at ptr+1
    logic shift_up;    // write read entry at ptr, ptr--
    logic write_new;   // write new timer at ptr, count++, id++
    logic shift_down;  // write read entry at ptr, ptr++
    logic pop_done;    // count--
    logic emit_acc;
    logic emit_full;
    logic emit_exp;
  } dtq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic scan_later;   // entry read is later than new deadline
    logic ptr_zero;
    logic shift_end;    // ptr + 1 == count
    logic head_due;
  } dtq_sts_t;
endpackage
`default_nettype wire

### rtl/deadline_timer_queue.sv
// channel   | handshake           | payload
// input     | start, busy         | in_i (operation, delay)
// result    | done_o strobe       | res_o (status, timer_id, last)
// insert: walks down from the top of the sorted store moving later entries up,
// a scan read and a scan compare state per entry moved; a full store is rejected without a scan.
// tick: a head read and check state per head check, plus a pop read and write state
// per entry shifted per expiry, and busy stays high to send the final word with last.
// reset clears time, id and count; the store contents need no clearing.
// results are one-cycle strobes; the receiver cannot stall.
// depends on dtq_pkg, dtq_ctrl, dtq_datapath
`default_nettype none
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_i,
  output logic          done_o,
  output out_word_t     res_o
);
  dtq_cmd_t cmd;
  dtq_sts_t sts;
  logic     busy_c;
  out_word_t res_raw;
  logic     vld_raw;
  logic     pend_q;
  out_word_t pend_w_q;

  dtq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start && !pend_q), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy_c)
  );
  dtq_datapath u_dp (
    .clk_i, .rst_ni, .in_i, .cmd_i(cmd), .sts_o(sts),
    .res_valid_o(vld_raw), .res_o(res_raw)
  );

  // expiry words are held back one slot so the final one can carry last
  logic flush;
  assign flush = pend_q && !busy_c && !vld_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (vld_raw && res_raw.status == StExpired) begin
        if (pend_q) done_o <= 1'b1;
        pend_q <= 1'b1;
      end else if (vld_raw) begin
        done_o <= 1'b1;
      end else if (flush) begin
        done_o <= 1'b1;
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_raw && res_raw.status == StExpired) begin
      if (pend_q) res_o <= pend_w_q;
      pend_w_q <= res_raw;
    end else if (vld_raw) begin
      res_o <= res_raw;
    end else if (flush) begin
      res_o <= '{status: pend_w_q.status, timer_id: pend_w_q.timer_id, last: 1'b1};
    end
  end

  assign busy = busy_c | pend_q;
endmodule
`default_nettype wire

### rtl/dtq_datapath.sv
// datapath: sorted timer store in memories, time and id counters, result word
// depends on dtq_pkg
`default_nettype none
module dtq_datapath
  import dtq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_word_t  in_i,
  input  wire dtq_cmd_t  cmd_i,
  output dtq_sts_t       sts_o,
  output logic           res_valid_o,
  output out_word_t      res_o
);
  logic [31:0] dl_mem [Capacity];
  logic [31:0] id_mem [Capacity];

  logic [31:0]   now_q, now_d, nid_q, nid_d;
  logic [CntW-1:0] cnt_q, cnt_d, ptr_q, ptr_d;
  logic          op_q;
  logic [31:0]   newdl_q;
  logic [31:0]   rdl_q, rid_q;
  logic          res_valid_q;
  out_word_t     res_q;
  logic [IdxW-1:0] ra, wa;
  logic          we;
  logic [31:0]   wdl, wid;

  // read address and write selection
  always_comb begin
    ra  = ptr_q[IdxW-1:0];
    wa  = ptr_q[IdxW-1:0];
    we  = cmd_i.shift_up | cmd_i.shift_down | cmd_i.write_new;
    wdl = rdl_q;
    wid = rid_q;
    if (cmd_i.rd_prev) begin
      ra = IdxW'(ptr_q - CntW'(1));
    end else if (cmd_i.rd_next) begin
      ra = IdxW'(ptr_q + CntW'(1));
    end
    if (cmd_i.write_new) begin
      wdl = newdl_q;
      wid = nid_q;
    end
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      dl_mem[wa] <= wdl;
      id_mem[wa] <= wid;
    end
    rdl_q <= dl_mem[ra];
    rid_q <= id_mem[ra];
  end

  // pointer, count, time and id
  always_comb begin
    now_d = now_q;
    nid_d = nid_q;
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    if (cmd_i.load_in && in_i.operation == OpTick) now_d = now_q + 32'd1;
    if (cmd_i.ptr_clr) ptr_d = '0;
    if (cmd_i.ptr_to_cnt) ptr_d = cnt_q;
    if (cmd_i.shift_up) ptr_d = ptr_q - CntW'(1);
    if (cmd_i.shift_down) ptr_d = ptr_q + CntW'(1);
    if (cmd_i.write_new) begin
      cnt_d = cnt_q + CntW'(1);
      nid_d = nid_q + 32'd1;
    end
    if (cmd_i.pop_done) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      nid_q       <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      now_q       <= now_d;
      nid_q       <= nid_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      res_valid_q <= cmd_i.emit_acc | cmd_i.emit_full | cmd_i.emit_exp;
    end
  end

  // captured input word and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= in_i.operation;
      newdl_q <= now_q + {8'd0, in_i.delay};
    end
    if (cmd_i.emit_acc) begin
      res_q <= '{status: StAccepted, timer_id: nid_q, last: 1'b1};
    end else if (cmd_i.emit_full) begin
      res_q <= '{status: StFull, timer_id: 32'd0, last: 1'b1};
    end else if (cmd_i.emit_exp) begin
      res_q <= '{status: StExpired, timer_id: rid_q, last: 1'b0};
    end
  end

  // status to controller
  logic [31:0] diff_later, diff_due;
  always_comb begin
    diff_later        = newdl_q - rdl_q;
    diff_due          = now_q - rdl_q;
    sts_o.is_tick     = op_q;
    sts_o.full        = (cnt_q == CntW'(Capacity));
    sts_o.empty       = (cnt_q == '0);
    sts_o.scan_later  = diff_later[31];
    sts_o.ptr_zero    = (ptr_q == '0);
    sts_o.shift_end   = (ptr_q + CntW'(1) == cnt_q);
    sts_o.head_due    = ~diff_due[31];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity)) else $error("count above capacity");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> cnt_q < CntW'(Capacity)) else $error("write into full store");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |-> cnt_q != '0) else $error("pop from empty store");
`endif
endmodule
`default_nettype wire

### rtl/dtq_ctrl.sv
// controller: sequences insert scan and shift, and tick pops
// depends on dtq_pkg
`default_nettype none
module dtq_ctrl
  import dtq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dtq_sts_t sts_i,
  output dtq_cmd_t      cmd_o,
  output logic          busy_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_CMP, S_WRITE,
    S_HEAD_RD, S_HEAD_CHK, S_POP_RD, S_POP_WR
  } state_e;

  state_e state_q;
  logic [EmitW-1:0] nemit_q;
  logic accept;

  assign accept = start_i && state_q == S_IDLE;
  assign busy_o = (state_q != S_IDLE);

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.load_in = accept;
    case (state_q)
      S_DECIDE: begin
        if (sts_i.is_tick) cmd_o.ptr_clr = 1'b1;
        else if (sts_i.full) cmd_o.emit_full = 1'b1;
        else cmd_o.ptr_to_cnt = 1'b1;
      end
      S_SCAN_RD:  cmd_o.rd_prev = 1'b1;
      S_SCAN_CMP: cmd_o.shift_up = sts_i.scan_later;
      S_WRITE: begin
        cmd_o.write_new = 1'b1;
        cmd_o.emit_acc  = 1'b1;
      end
      S_HEAD_CHK: begin
        if (!sts_i.empty && sts_i.head_due && nemit_q != EmitW'(MaxResults)) begin
          cmd_o.emit_exp = 1'b1;
        end
      end
      S_POP_RD: cmd_o.rd_next = 1'b1;
      S_POP_WR: begin
        if (!sts_i.shift_end) begin
          cmd_o.shift_down = 1'b1;
        end else begin
          cmd_o.pop_done = 1'b1;
          cmd_o.ptr_clr  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state and expiry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nemit_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (accept) state_q <= S_DECIDE;
        S_DECIDE: begin
          nemit_q <= '0;
          if (sts_i.is_tick) state_q <= S_HEAD_RD;
          else if (sts_i.full) state_q <= S_IDLE;
          else state_q <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          // walk down from the top, nothing left below at zero
          if (sts_i.ptr_zero) state_q <= S_WRITE;
          else state_q <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (sts_i.scan_later) state_q <= S_SCAN_RD;
          else state_q <= S_WRITE;
        end
        S_WRITE: state_q <= S_IDLE;
        S_HEAD_RD: state_q <= S_HEAD_CHK;
        S_HEAD_CHK: begin
          if (!sts_i.empty && sts_i.head_due && nemit_q != EmitW'(MaxResults)) begin
            nemit_q <= nemit_q + EmitW'(1);
            state_q <= S_POP_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_POP_RD: state_q <= S_POP_WR;
        S_POP_WR: begin
          if (sts_i.shift_end) state_q <= S_HEAD_RD;
          else state_q <= S_POP_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("not busy after accept");
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_acc, cmd_o.emit_full, cmd_o.emit_exp}))
    else $error("two result words at once");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nemit_q <= EmitW'(MaxResults)) else $error("too many expiries");
`endif
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// testbench for deadline_timer_queue: predicts accept, full and expiry words
// from a local copy of the sorted timer store; depends on dtq_pkg and the rtl
`default_nettype none
module testbench;
  import dtq_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_i = '0;
  logic      done_o;
  out_word_t res_o;

  deadline_timer_queue uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .done_o(done_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] tq_deadline[Capacity];
  logic [31:0] tq_ident[Capacity];
  int unsigned tq_count = 0;
  logic [31:0] now_ticks = '0;
  logic [31:0] id_next = '0;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned expiries_seen = 0;
  int unsigned fulls_seen = 0;
  int unsigned gap_left = 0;
  bit          calm = 1'b0;
  bit          busy_seen = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic out_word_t mk_word(logic [1:0] st, logic [31:0] id, logic lst);
    out_word_t w;
    w.status = st;
    w.timer_id = id;
    w.last = lst;
    return w;
  endfunction

  // append to the tail of the queues
  function automatic void add_expected(input out_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void add_pending(input in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // work out the words that one accepted input word causes
  task automatic predict_timer_words(input in_word_t w);
    logic [31:0] dl;
    int unsigned pos;
    int unsigned n;
    int last_ix;
    out_word_t r;
    if (w.operation == OpInsert) begin
      if (tq_count >= Capacity) begin
        add_expected(mk_word(StFull, '0, 1'b1));
      end else begin
        dl = now_ticks + {8'd0, w.delay};
        pos = 0;
        while (pos < tq_count && !(($signed(dl - tq_deadline[pos])) < 0)) pos++;
        for (int i = int'(tq_count); i > int'(pos); i--) begin
          tq_deadline[i] = tq_deadline[i-1];
          tq_ident[i] = tq_ident[i-1];
        end
        tq_deadline[pos] = dl;
        tq_ident[pos] = id_next;
        tq_count++;
        add_expected(mk_word(StAccepted, id_next, 1'b1));
        id_next++;
      end
    end else begin
      now_ticks++;
      n = 0;
      while (n < MaxResults && tq_count > 0 && $signed(now_ticks - tq_deadline[0]) >= 0) begin
        add_expected(mk_word(StExpired, tq_ident[0], 1'b0));
        for (int i = 1; i < tq_count; i++) begin
          tq_deadline[i-1] = tq_deadline[i];
          tq_ident[i-1] = tq_ident[i];
        end
        tq_count--;
        n++;
      end
      if (n > 0) begin
        last_ix = expected_words.size() - 1;
        r = expected_words[last_ix];
        r.last = 1'b1;
        expected_words[last_ix] = r;
      end
    end
  endtask

  task automatic report(input string what, input out_word_t got, input out_word_t want);
    mismatches++;
    $display("error at %0t: %s got st=%0d id=%0d last=%0d want st=%0d id=%0d last=%0d",
             $realtime, what, got.status, got.timer_id, got.last,
             want.status, want.timer_id, want.last);
  endtask

  // driver: one word per handshake, random gaps between words
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // busy at the last rising edge tells whether the word was taken there
      if (!(start && busy_seen)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_i <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
      busy_seen = busy;
    end
  end

  // monitor: predict on accept, check every strobe
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (start && !busy) begin
        predict_timer_words(in_i);
        words_sent++;
        idle_cycles = 0;
      end
      if (done_o) begin
        idle_cycles = 0;
        words_checked++;
        if (res_o.status == StExpired) expiries_seen++;
        if (res_o.status == StFull) fulls_seen++;
        if (expected_words.size() == 0) begin
          report("unexpected word", res_o, '0);
        end else begin
          want = expected_words.pop_front();
          if (res_o.status != want.status) report("status", res_o, want);
          else if (res_o.timer_id != want.timer_id) report("timer_id", res_o, want);
          else if (res_o.last != want.last) report("last", res_o, want);
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic in_word_t mk_in(logic op, logic [23:0] d);
    in_word_t w;
    w.operation = op;
    w.delay = d;
    return w;
  endfunction

  task automatic add_ticks(input int unsigned n);
    for (int i = 0; i < n; i++) add_pending(mk_in(OpTick, 24'($urandom())));
  endtask

  initial begin
    int unsigned r;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: zero delay, ties, fill to full, overflow, large delay
    add_pending(mk_in(OpTick, 24'hFFFFFF));
    add_pending(mk_in(OpInsert, 24'd0));
    add_pending(mk_in(OpInsert, 24'd0));
    add_pending(mk_in(OpInsert, 24'hFFFFFF));
    add_ticks(1);
    for (int i = 0; i < 15; i++) add_pending(mk_in(OpInsert, 24'(i % 3)));
    add_pending(mk_in(OpInsert, 24'd5));
    add_pending(mk_in(OpInsert, 24'd5));
    add_ticks(4);

    // random: bursts of inserts with short delays, then ticks
    while (pending_words.size() < 480) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        for (int k = $urandom_range(1, 18); k > 0; k--)
          add_pending(mk_in(OpInsert,
            ($urandom_range(0, 15) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 12))));
      end else begin
        add_ticks($urandom_range(1, 14));
      end
    end
    // drain what can expire soon; last stretch without gaps
    add_ticks(20);

    while (pending_words.size() > 60) @(posedge clk_i);
    calm = 1'b1;
    while (pending_words.size() > 0 || start || busy || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("sent %0d input words, checked %0d result words", words_sent, words_checked);
    $display("expiries %0d, full rejects %0d", expiries_seen, fulls_seen);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/dtq_pkg.sv
rtl/dtq_datapath.sv
rtl/dtq_ctrl.sv
rtl/deadline_timer_queue.sv
tb/sv/testbench.sv
